### sv/assert_macros.svh
// Concurrent assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, expr, msg)
`endif

`endif

### sv/i2cmw_pkg.sv
// Shared types and constants for the I2C motor write master
package i2cmw_pkg;

    localparam logic [7:0]  ADDR_BASE         = 8'h50;
    localparam logic [15:0] PHASE_TICKS_RESET = 16'd5;

    localparam logic [4:0] ST_IDLE  = 5'd0;
    localparam logic [4:0] ST_S1    = 5'd1;
    localparam logic [4:0] ST_S2    = 5'd2;
    localparam logic [4:0] ST_S3    = 5'd3;
    localparam logic [4:0] ST_BSET  = 5'd4;
    localparam logic [4:0] ST_BWAIT = 5'd5;
    localparam logic [4:0] ST_BHIGH = 5'd6;
    localparam logic [4:0] ST_A0    = 5'd7;
    localparam logic [4:0] ST_A1    = 5'd8;
    localparam logic [4:0] ST_A2    = 5'd9;
    localparam logic [4:0] ST_A3    = 5'd10;
    localparam logic [4:0] ST_A4    = 5'd11;
    localparam logic [4:0] ST_P1    = 5'd12;
    localparam logic [4:0] ST_PWAIT = 5'd13;
    localparam logic [4:0] ST_P2    = 5'd14;
    localparam logic [4:0] ST_P3    = 5'd15;
    localparam logic [4:0] ST_TAIL  = 5'd16;

    typedef struct packed {
        logic       start_req;
        logic [7:0] motor_index;
        logic [7:0] motor_value;
        logic       scl_sense;
    } item_t;

    typedef struct packed {
        logic scl_release;
        logic sda_release;
        logic busy_res;
        logic done_res;
    } result_t;

endpackage

### sv/i2cmw_seq.sv
// Bit-level I2C write sequencer: state registers and next-state logic for each step
`include "assert_macros.svh"

module i2cmw_seq
    import i2cmw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        step,
    input  item_t       item,
    input  logic [15:0] phase_ticks,
    output result_t     result
);

    logic [4:0]  state_reg,    state_next;
    logic [15:0] delay_reg,    delay_next;
    logic [2:0]  bit_cnt_reg,  bit_cnt_next;
    logic        byte_sel_reg, byte_sel_next;
    logic [7:0]  shift_reg,    shift_next;
    logic [7:0]  held_reg,     held_next;
    logic        scl_reg,      scl_next;
    logic        sda_reg,      sda_next;
    logic        done;
    logic [15:0] load;

    assign load = (phase_ticks == 16'd0) ? 16'd1 : phase_ticks;

    always_comb
    begin
        state_next    = state_reg;
        delay_next    = delay_reg;
        bit_cnt_next  = bit_cnt_reg;
        byte_sel_next = byte_sel_reg;
        shift_next    = shift_reg;
        held_next     = held_reg;
        scl_next      = scl_reg;
        sda_next      = sda_reg;
        done          = 1'b0;

        unique case (state_reg) inside
            ST_IDLE:
            begin
                if (item.start_req)
                begin
                    shift_next    = ADDR_BASE + {item.motor_index[6:0], 1'b0};
                    held_next     = item.motor_value;
                    byte_sel_next = 1'b0;
                    bit_cnt_next  = 3'd0;
                    scl_next      = 1'b1;
                    sda_next      = 1'b1;
                    state_next    = ST_S1;
                    delay_next    = load;
                end
            end
            ST_BWAIT:
            begin
                if (item.scl_sense)
                begin
                    state_next = ST_BHIGH;
                    delay_next = load;
                end
            end
            ST_PWAIT:
            begin
                if (item.scl_sense)
                begin
                    state_next = ST_P2;
                    delay_next = load;
                end
            end
            ST_S1, ST_S2, ST_S3, ST_BSET, ST_BHIGH, ST_A0, ST_A1, ST_A2, ST_A3, ST_A4,
            ST_P1, ST_P2, ST_P3, ST_TAIL:
            begin
                if (delay_reg > 16'd1)
                begin
                    delay_next = delay_reg - 16'd1;
                end
                else
                begin
                    delay_next = load;
                    unique case (state_reg)
                        ST_S1:
                        begin
                            sda_next   = 1'b0;
                            state_next = ST_S2;
                        end
                        ST_S2:
                        begin
                            scl_next   = 1'b0;
                            state_next = ST_S3;
                        end
                        ST_S3:
                        begin
                            sda_next   = shift_reg[7];
                            state_next = ST_BSET;
                        end
                        ST_BSET:
                        begin
                            scl_next   = 1'b1;
                            delay_next = delay_reg;
                            state_next = ST_BWAIT;
                        end
                        ST_BHIGH:
                        begin
                            scl_next     = 1'b0;
                            shift_next   = {shift_reg[6:0], 1'b0};
                            bit_cnt_next = bit_cnt_reg + 3'd1;
                            if (bit_cnt_reg == 3'd7)
                            begin
                                state_next = ST_A0;
                            end
                            else
                            begin
                                sda_next   = shift_reg[6];
                                state_next = ST_BSET;
                            end
                        end
                        ST_A0:
                        begin
                            sda_next   = 1'b1;
                            state_next = ST_A1;
                        end
                        ST_A1:
                        begin
                            scl_next   = 1'b1;
                            state_next = ST_A2;
                        end
                        ST_A2:
                        begin
                            state_next = ST_A3;
                        end
                        ST_A3:
                        begin
                            scl_next   = 1'b0;
                            state_next = ST_A4;
                        end
                        ST_A4:
                        begin
                            if (!byte_sel_reg)
                            begin
                                byte_sel_next = 1'b1;
                                shift_next    = held_reg;
                                sda_next      = held_reg[7];
                                state_next    = ST_BSET;
                            end
                            else
                            begin
                                sda_next   = 1'b0;
                                state_next = ST_P1;
                            end
                        end
                        ST_P1:
                        begin
                            scl_next   = 1'b1;
                            delay_next = delay_reg;
                            state_next = ST_PWAIT;
                        end
                        ST_P2:
                        begin
                            sda_next   = 1'b1;
                            state_next = ST_P3;
                        end
                        ST_P3:
                        begin
                            state_next = ST_TAIL;
                        end
                        ST_TAIL:
                        begin
                            state_next = ST_IDLE;
                            delay_next = 16'd0;
                            done       = 1'b1;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                            delay_next = 16'd0;
                        end
                    endcase
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                delay_next = 16'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            delay_reg    <= 16'd0;
            bit_cnt_reg  <= 3'd0;
            byte_sel_reg <= 1'b0;
            shift_reg    <= 8'd0;
            held_reg     <= 8'd0;
            scl_reg      <= 1'b1;
            sda_reg      <= 1'b1;
        end
        else if (step)
        begin
            state_reg    <= state_next;
            delay_reg    <= delay_next;
            bit_cnt_reg  <= bit_cnt_next;
            byte_sel_reg <= byte_sel_next;
            shift_reg    <= shift_next;
            held_reg     <= held_next;
            scl_reg      <= scl_next;
            sda_reg      <= sda_next;
        end
    end

    assign result.scl_release = scl_next;
    assign result.sda_release = sda_next;
    assign result.busy_res    = (state_next != ST_IDLE);
    assign result.done_res    = done;

    `ASSERT_CLK(a_done_to_idle, clk, rst_n, step && done |=> state_reg == ST_IDLE, "done without return to idle")
    `ASSERT_CLK(a_delay_loaded, clk, rst_n, state_reg != ST_IDLE |-> delay_reg != 16'd0, "active phase with empty delay count")
    `ASSERT_CLK(a_hold_no_step, clk, rst_n, !step |=> $stable(state_reg) && $stable(bit_cnt_reg), "state moved without a request")

endmodule

### sv/i2c_motor_write_master.sv
// I2C motor write master top level: request register, sequencer, result register.
// A request passes the request register, then the result register; out_stall may hold it between.
// Throughput: one request per cycle; only a stall on the result side holds the input back.
// Reset: asynchronous, active low; sequencer idle, its line registers released, phase_ticks = 5.
module i2c_motor_write_master
    import i2cmw_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        start_req,
    input  logic [7:0]  motor_index,
    input  logic [7:0]  motor_value,
    input  logic        scl_sense,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        scl_release,
    output logic        sda_release,
    output logic        busy_res,
    output logic        done_res
);

    logic [15:0] phase_ticks_reg;
    logic        req_valid_reg;
    item_t       item_reg;
    logic        res_valid_reg;
    result_t     res_reg;
    result_t     step_res;
    logic        advance;

    assign advance  = req_valid_reg && (!res_valid_reg || !out_stall);
    assign in_stall = req_valid_reg && res_valid_reg && out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_ticks_reg <= PHASE_TICKS_RESET;
            req_valid_reg   <= 1'b0;
            res_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                phase_ticks_reg <= cfg_wdata;
            end
            if (!in_stall)
            begin
                req_valid_reg <= in_valid;
            end
            if (advance)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            item_reg.start_req   <= start_req;
            item_reg.motor_index <= motor_index;
            item_reg.motor_value <= motor_value;
            item_reg.scl_sense   <= scl_sense;
        end
        if (advance)
        begin
            res_reg <= step_res;
        end
    end

    i2cmw_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (advance),
        .item        (item_reg),
        .phase_ticks (phase_ticks_reg),
        .result      (step_res)
    );

    assign out_valid   = res_valid_reg;
    assign scl_release = res_reg.scl_release;
    assign sda_release = res_reg.sda_release;
    assign busy_res    = res_reg.busy_res;
    assign done_res    = res_reg.done_res;

endmodule
